>>> rtl/osbp_pkg.sv
package osbp_pkg;

    localparam int OP_W          = 3;
    localparam int SLOT_FIELD_W  = 3;
    localparam int INDEX_FIELD_W = 14;
    localparam int SAMPLE_W      = 16;
    localparam int NLEN_W        = 16;
    localparam int STEP_FIELD_W  = 36;
    localparam int AUDIO_W       = 32;
    localparam int SLEN_W        = 15;
    localparam int FRAC_W        = 32;
    localparam int FRAC_HI_W     = 16;
    localparam int S_TDATA_W     = 88;
    localparam int M_TDATA_W     = 56;
    localparam int FIFO_DEPTH    = 4;
    localparam int MIN_PLAY_LEN  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 3'd0,
        OP_LENGTH  = 3'd1,
        OP_TRIGGER = 3'd2,
        OP_STOP    = 3'd3,
        OP_NEXT    = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        MODE_ZERO,
        MODE_SINGLE,
        MODE_INTERP
    } t_mode;

    typedef struct packed {
        logic [S_TDATA_W-SLOT_FIELD_W-INDEX_FIELD_W-SAMPLE_W-NLEN_W-STEP_FIELD_W-1:0] pad;
        logic [STEP_FIELD_W-1:0]    step;
        logic [NLEN_W-1:0]          new_length;
        logic signed [SAMPLE_W-1:0] sample_value;
        logic [INDEX_FIELD_W-1:0]   sample_index;
        logic [SLOT_FIELD_W-1:0]    slot;
    } t_in_word;

    typedef struct packed {
        logic [M_TDATA_W-AUDIO_W-SLEN_W-3-1:0] pad;
        logic                      any_playing;
        logic                      slot_playing;
        logic [SLEN_W-1:0]         slot_length;
        logic                      rejected;
        logic signed [AUDIO_W-1:0] audio_out;
    } t_out_word;

endpackage

>>> rtl/oneshot_sample_bank_player_core.sv
// Bank of one-shot sample players with linear interpolation.
// Input words arrive on the s_axis channel: tuser carries the operation and
// tdata the slot, sample index, sample value, new length and step. Each input
// word gives exactly one result word on the m_axis channel, carrying the
// audio sample, the reject flag, the slot length and the playing flags.
// Samples sit in one single-port memory; the per-slot records (length,
// playhead, step) sit in a small second memory, read when a word is accepted
// and written back in the following cycle. Active flags are held in flip-flops.
// No word is accepted while the previous one is in stage p1, because the record
// is written back in the cycle after acceptance and a next-sample request uses
// the sample port for two consecutive reads. A word passes stages p1, p2 and p3
// to the output buffer; a new one may be accepted while it is in p2 or p3.
// When the receiver stalls, results queue in a four-word output buffer;
// acceptance continues until four words are outstanding, so nothing is lost.
// Reset clears all slot lengths, playheads and active flags and empties the
// pipeline; the sample memory is not cleared and holds garbage until written.
module oneshot_sample_bank_player_core
    import osbp_pkg::*;
#(
    parameter int SLOT_COUNT      = 8,
    parameter int SLOT_SAMPLES    = 16384,
    parameter int STEP_WHOLE_BITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // slot, sample_index, sample_value, new_length, step, zero padding
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // op
    input  logic [OP_W-1:0]      s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // audio_out, rejected, slot_length, slot_playing, any_playing, zero padding
    output logic [M_TDATA_W-1:0] m_axis_tdata
);

    localparam int SLOT_W       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int IDX_W        = $clog2(SLOT_SAMPLES);
    localparam int REGION       = 1 << IDX_W;
    localparam int SAMPLE_DEPTH = SLOT_COUNT * REGION;
    localparam int LEN_W        = $clog2(SLOT_SAMPLES + 1);
    localparam int WHOLE_W      = ((LEN_W > STEP_WHOLE_BITS) ? LEN_W : STEP_WHOLE_BITS) + 1;
    localparam int STEP_W       = FRAC_W + STEP_WHOLE_BITS;
    localparam int POS_W        = WHOLE_W + FRAC_W;
    localparam int CREDIT_W     = $clog2(FIFO_DEPTH + 1);
    localparam int PTR_W        = $clog2(FIFO_DEPTH) + 1;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [WHOLE_W-1:0] whole;
        logic [FRAC_W-1:0]  frac;
        logic [STEP_W-1:0]  step;
    } t_rec;

    t_in_word                   w_in;
    logic                       w_accept;
    logic                       w_deliver;
    logic                       w_in_valid;
    logic [SLOT_W-1:0]          w_in_sidx;

    t_rec                       r_slot_mem [SLOT_COUNT];
    t_rec                       r_rec;
    logic                       r_rec_ok;
    logic [SLOT_COUNT-1:0]      r_loaded;
    logic [SLOT_COUNT-1:0]      r_active;

    logic signed [SAMPLE_W-1:0] r_sample_mem [SAMPLE_DEPTH];
    logic signed [SAMPLE_W-1:0] r_rdata;

    logic                       r_p1_v;
    t_in_word                   r_p1_word;
    logic [OP_W-1:0]            r_p1_op;
    logic                       w_p1_valid;
    logic [SLOT_W-1:0]          w_p1_sidx;
    t_rec                       w_cur;
    logic                       w_cur_act;
    logic [POS_W-1:0]           w_pos;
    logic [WHOLE_W-1:0]         w_whole_inc;
    logic [STEP_W-1:0]          w_step_keep;
    t_rec                       n_rec;
    logic                       n_act;
    logic [SLOT_COUNT-1:0]      n_active;
    logic                       w_rej;
    t_mode                      w_mode;
    logic                       w_swe;
    logic                       w_sre;
    logic [IDX_W-1:0]           w_p1_idx;
    t_out_word                  w_p1_out;

    logic                       r_p2_v;
    logic [SLOT_W-1:0]          r_p2_sidx;
    logic [IDX_W-1:0]           r_p2_idx1;
    t_mode                      r_p2_mode;
    logic [FRAC_HI_W-1:0]       r_p2_frac_hi;
    t_out_word                  r_p2_word;

    logic                       r_p3_v;
    t_mode                      r_p3_mode;
    logic [FRAC_HI_W-1:0]       r_p3_frac_hi;
    logic signed [SAMPLE_W-1:0] r_p3_s0;
    t_out_word                  r_p3_word;
    logic signed [SAMPLE_W:0]   w_diff;
    logic signed [FRAC_HI_W:0]  w_frac_s;
    logic signed [2*FRAC_HI_W+1:0] w_prod;
    logic [AUDIO_W-1:0]         w_base;
    t_out_word                  w_result;

    logic                       w_mem_we;
    logic                       w_mem_re;
    logic [SLOT_W+IDX_W-1:0]    w_mem_addr;

    t_out_word                  r_fifo [FIFO_DEPTH];
    logic [PTR_W-1:0]           r_wr_ptr;
    logic [PTR_W-1:0]           r_rd_ptr;
    logic [CREDIT_W-1:0]        r_credit;

    assign w_in       = s_axis_tdata;
    assign w_in_valid = 32'(w_in.slot) < SLOT_COUNT;
    assign w_in_sidx  = SLOT_W'(w_in.slot);

    assign s_axis_tready = !r_p1_v && (r_credit < CREDIT_W'(FIFO_DEPTH));
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_wr_ptr != r_rd_ptr);
    assign m_axis_tdata  = r_fifo[r_rd_ptr[PTR_W-2:0]];
    assign w_deliver     = m_axis_tvalid && m_axis_tready;

    assign w_p1_valid  = 32'(r_p1_word.slot) < SLOT_COUNT;
    assign w_p1_sidx   = SLOT_W'(r_p1_word.slot);
    assign w_cur       = r_rec_ok ? r_rec : '0;
    assign w_cur_act   = w_p1_valid && r_active[w_p1_sidx];
    assign w_pos       = {w_cur.whole, w_cur.frac} + POS_W'(w_cur.step);
    assign w_whole_inc = w_cur.whole + WHOLE_W'(1);
    assign w_step_keep = STEP_W'(r_p1_word.step);

    always_comb begin
        n_rec    = w_cur;
        n_act    = w_cur_act;
        w_rej    = 1'b0;
        w_mode   = MODE_ZERO;
        w_swe    = 1'b0;
        w_sre    = 1'b0;
        w_p1_idx = IDX_W'(w_cur.whole);
        unique case (r_p1_op)
            OP_WRITE: begin
                if (w_p1_valid && (32'(r_p1_word.sample_index) < SLOT_SAMPLES)) begin
                    w_swe    = 1'b1;
                    w_p1_idx = IDX_W'(r_p1_word.sample_index);
                end
            end
            OP_LENGTH: begin
                if (!w_p1_valid || (32'(r_p1_word.new_length) > SLOT_SAMPLES)) begin
                    w_rej = 1'b1;
                end else begin
                    n_rec     = '0;
                    n_rec.len = LEN_W'(r_p1_word.new_length);
                    n_act     = 1'b0;
                end
            end
            OP_TRIGGER: begin
                if (!w_p1_valid || (32'(w_cur.len) < MIN_PLAY_LEN)) begin
                    w_rej = 1'b1;
                end else begin
                    n_rec.whole = '0;
                    n_rec.frac  = '0;
                    n_rec.step  = (w_step_keep == '0) ? STEP_W'(1) : w_step_keep;
                    n_act       = 1'b1;
                end
            end
            OP_STOP: begin
                if (w_p1_valid) begin
                    n_rec.whole = '0;
                    n_rec.frac  = '0;
                    n_rec.step  = '0;
                    n_act       = 1'b0;
                end
            end
            OP_NEXT: begin
                if (w_cur_act && (32'(w_cur.len) >= MIN_PLAY_LEN)) begin
                    if (w_cur.whole >= WHOLE_W'(w_cur.len)) begin
                        n_act = 1'b0;
                    end else if (w_whole_inc >= WHOLE_W'(w_cur.len)) begin
                        n_act       = 1'b0;
                        n_rec.whole = WHOLE_W'(w_cur.len);
                        w_mode      = MODE_SINGLE;
                        w_sre       = 1'b1;
                    end else begin
                        n_rec.whole = w_pos[POS_W-1:FRAC_W];
                        n_rec.frac  = w_pos[FRAC_W-1:0];
                        n_act       = w_pos[POS_W-1:FRAC_W] < WHOLE_W'(w_cur.len);
                        w_mode      = MODE_INTERP;
                        w_sre       = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_active = r_active;
        if (w_p1_valid) begin
            n_active[w_p1_sidx] = n_act;
        end
        w_p1_out              = '0;
        w_p1_out.rejected     = w_rej;
        w_p1_out.slot_length  = w_p1_valid ? SLEN_W'(n_rec.len) : '0;
        w_p1_out.slot_playing = w_p1_valid && n_act;
        w_p1_out.any_playing  = |n_active;
    end

    assign w_mem_we   = r_p1_v && w_swe;
    assign w_mem_re   = (r_p1_v && w_sre) || (r_p2_v && (r_p2_mode == MODE_INTERP));
    assign w_mem_addr = r_p1_v ? {w_p1_sidx, w_p1_idx} : {r_p2_sidx, r_p2_idx1};

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_sample_mem[w_mem_addr] <= r_p1_word.sample_value;
        end else if (w_mem_re) begin
            r_rdata <= r_sample_mem[w_mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_in_valid) begin
            r_rec <= r_slot_mem[w_in_sidx];
        end
        if (r_p1_v && w_p1_valid) begin
            r_slot_mem[w_p1_sidx] <= n_rec;
        end
    end

    assign w_diff   = {r_rdata[SAMPLE_W-1], r_rdata} - {r_p3_s0[SAMPLE_W-1], r_p3_s0};
    assign w_frac_s = {1'b0, r_p3_frac_hi};
    assign w_prod   = w_diff * w_frac_s;
    assign w_base   = {r_p3_s0, {(AUDIO_W-SAMPLE_W){1'b0}}};

    always_comb begin
        w_result = r_p3_word;
        unique case (r_p3_mode)
            MODE_INTERP: w_result.audio_out = w_base + w_prod[AUDIO_W-1:0];
            MODE_SINGLE: w_result.audio_out = w_base;
            default:     w_result.audio_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p1_word <= w_in;
            r_p1_op   <= s_axis_tuser;
            r_rec_ok  <= w_in_valid && r_loaded[w_in_sidx];
        end
        if (r_p1_v) begin
            r_p2_sidx    <= w_p1_sidx;
            r_p2_idx1    <= IDX_W'(w_whole_inc);
            r_p2_mode    <= w_mode;
            r_p2_frac_hi <= w_cur.frac[FRAC_W-1:FRAC_W-FRAC_HI_W];
            r_p2_word    <= w_p1_out;
        end
        if (r_p2_v) begin
            r_p3_mode    <= r_p2_mode;
            r_p3_frac_hi <= r_p2_frac_hi;
            r_p3_s0      <= r_rdata;
            r_p3_word    <= r_p2_word;
        end
        if (r_p3_v) begin
            r_fifo[r_wr_ptr[PTR_W-2:0]] <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v   <= 1'b0;
            r_p2_v   <= 1'b0;
            r_p3_v   <= 1'b0;
            r_active <= '0;
            r_loaded <= '0;
            r_credit <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_p1_v <= w_accept;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
            if (r_p1_v) begin
                r_active <= n_active;
                if (w_p1_valid) begin
                    r_loaded[w_p1_sidx] <= 1'b1;
                end
            end
            r_credit <= r_credit + CREDIT_W'(w_accept) - CREDIT_W'(w_deliver);
            if (r_p3_v) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_deliver) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
        end
    end

`ifndef SYNTHESIS
    a_stage_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_p1_v && r_p2_v))
        else $error("record update and second sample read overlap");

    a_credit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_credit <= CREDIT_W'(FIFO_DEPTH))
        else $error("more words outstanding than the output buffer holds");

    a_fill_within_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CREDIT_W'(r_wr_ptr - r_rd_ptr) <= r_credit)
        else $error("output buffer holds more words than are outstanding");

    a_accept_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("word accepted while the slot record is being written back");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import osbp_pkg::*;

    localparam int SLOT_COUNT      = 8;
    localparam int SLOT_SAMPLES    = 16384;
    localparam int STEP_WHOLE_BITS = 4;
    localparam logic [63:0] STEP_KEEP = (64'd1 << (FRAC_W + STEP_WHOLE_BITS)) - 64'd1;
    localparam int RESET_CYCLES  = 5;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int PRINT_LIMIT   = 100;

    typedef struct {
        logic [OP_W-1:0] op;
        t_in_word        word;
        bit              drain;
    } t_bank_cmd;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [OP_W-1:0]      s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    // Predictor state, one copy per slot.
    logic signed [SAMPLE_W-1:0] bank_mem [SLOT_COUNT*SLOT_SAMPLES];
    logic [31:0]           pb_len   [SLOT_COUNT];
    logic [31:0]           pb_whole [SLOT_COUNT];
    logic [FRAC_W-1:0]     pb_frac  [SLOT_COUNT];
    logic [63:0]           pb_step  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] pb_active = '0;

    // Stimulus generator's view: which samples hold data and the slot lengths.
    bit sample_known [SLOT_COUNT][SLOT_SAMPLES];
    int known_run    [SLOT_COUNT];
    int gen_len      [SLOT_COUNT];
    bit drain_next = 1'b0;

    t_bank_cmd cmd_queue [$];
    t_out_word due_outputs [$];
    t_bank_cmd cur_cmd;

    int rst_cycles     = 0;
    int cycle_count    = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int next_long_hold = 150;
    int hold_left      = 0;
    int tx_gap         = 0;
    int rx_gap         = 0;
    int tx_calm        = 0;
    int rx_calm        = 0;

    oneshot_sample_bank_player_core #(
        .SLOT_COUNT      (SLOT_COUNT),
        .SLOT_SAMPLES    (SLOT_SAMPLES),
        .STEP_WHOLE_BITS (STEP_WHOLE_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (rst_cycles < RESET_CYCLES) begin
            rst_cycles <= rst_cycles + 1;
            i_rst_n    <= 1'b0;
        end else begin
            i_rst_n <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("oneshot_sample_bank_player_core: mismatch");
            $finish;
        end
    end

    function automatic void slot_halt(int unsigned s);
        pb_active[s] = 1'b0;
        pb_whole[s]  = '0;
        pb_frac[s]   = '0;
        pb_step[s]   = '0;
    endfunction

    function automatic logic [AUDIO_W-1:0] play_next(int unsigned s);
        logic [31:0] len;
        logic [31:0] i0;
        longint      s0;
        longint      d;
        longint      acc;
        logic [63:0] pos;
        len = pb_len[s];
        i0  = pb_whole[s];
        if (!pb_active[s] || len < MIN_PLAY_LEN) begin
            return '0;
        end
        if (i0 >= len) begin
            pb_active[s] = 1'b0;
            return '0;
        end
        s0 = longint'(bank_mem[s*SLOT_SAMPLES + int'(i0)]);
        // The final sample is played alone and ends the run.
        if (i0 + 1 >= len) begin
            pb_active[s] = 1'b0;
            pb_whole[s]  = len;
            acc = s0 <<< FRAC_HI_W;
            return acc[AUDIO_W-1:0];
        end
        d   = longint'(bank_mem[s*SLOT_SAMPLES + int'(i0) + 1]) - s0;
        acc = (s0 <<< FRAC_HI_W)
            + d * longint'(pb_frac[s][FRAC_W-1:FRAC_W-FRAC_HI_W]);
        pos = {i0, pb_frac[s]} + pb_step[s];
        pb_whole[s] = pos[63:32];
        pb_frac[s]  = pos[31:0];
        if (pb_whole[s] >= len) begin
            pb_active[s] = 1'b0;
        end
        return acc[AUDIO_W-1:0];
    endfunction

    function automatic t_out_word bank_apply(logic [OP_W-1:0] op, t_in_word w);
        t_out_word   r;
        int unsigned s;
        bit          valid;
        logic [63:0] stp;
        r     = '0;
        s     = w.slot;
        valid = s < SLOT_COUNT;
        case (op)
            OP_WRITE: begin
                if (valid && w.sample_index < SLOT_SAMPLES) begin
                    bank_mem[s*SLOT_SAMPLES + int'(w.sample_index)] = w.sample_value;
                end
            end
            OP_LENGTH: begin
                if (!valid || w.new_length > SLOT_SAMPLES) begin
                    r.rejected = 1'b1;
                end else begin
                    slot_halt(s);
                    pb_len[s] = 32'(w.new_length);
                end
            end
            OP_TRIGGER: begin
                if (!valid || pb_len[s] < MIN_PLAY_LEN) begin
                    r.rejected = 1'b1;
                end else begin
                    stp = 64'(w.step) & STEP_KEEP;
                    pb_step[s]   = (stp == '0) ? 64'd1 : stp;
                    pb_whole[s]  = '0;
                    pb_frac[s]   = '0;
                    pb_active[s] = 1'b1;
                end
            end
            OP_STOP: begin
                if (valid) begin
                    slot_halt(s);
                end
            end
            OP_NEXT: begin
                if (valid) begin
                    r.audio_out = play_next(s);
                end
            end
            default: begin
            end
        endcase
        r.any_playing  = |pb_active;
        r.slot_length  = valid ? pb_len[s][SLEN_W-1:0] : '0;
        r.slot_playing = valid && pb_active[s];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (mismatch_count < PRINT_LIMIT) begin
            $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_output(t_out_word got);
        t_out_word want;
        if (due_outputs.size() == 0) begin
            report_mismatch("result word with nothing due", longint'(got.audio_out), 0);
            return;
        end
        want = due_outputs.pop_front();
        if (got.audio_out !== want.audio_out) begin
            report_mismatch("audio_out", longint'(got.audio_out), longint'(want.audio_out));
        end
        if (got.rejected !== want.rejected) begin
            report_mismatch("rejected", longint'(got.rejected), longint'(want.rejected));
        end
        if (got.slot_length !== want.slot_length) begin
            report_mismatch("slot_length", longint'(got.slot_length),
                            longint'(want.slot_length));
        end
        if (got.slot_playing !== want.slot_playing) begin
            report_mismatch("slot_playing", longint'(got.slot_playing),
                            longint'(want.slot_playing));
        end
        if (got.any_playing !== want.any_playing) begin
            report_mismatch("any_playing", longint'(got.any_playing),
                            longint'(want.any_playing));
        end
    endtask

    // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
    function automatic int idle_len(ref int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        w              = '0;
        w.slot         = SLOT_FIELD_W'($urandom);
        w.sample_index = INDEX_FIELD_W'($urandom);
        w.sample_value = SAMPLE_W'($urandom);
        w.new_length   = NLEN_W'($urandom);
        w.step         = STEP_FIELD_W'({$urandom, $urandom});
        return w;
    endfunction

    task automatic push_cmd(logic [OP_W-1:0] op, t_in_word w);
        t_bank_cmd c;
        c.op       = op;
        c.word     = w;
        c.drain    = drain_next;
        drain_next = 1'b0;
        cmd_queue.push_back(c);
    endtask

    task automatic gen_simple(logic [OP_W-1:0] op, int s);
        t_in_word w;
        w      = rand_word();
        w.slot = SLOT_FIELD_W'(s);
        push_cmd(op, w);
    endtask

    task automatic gen_write(int s, int idx, int val);
        t_in_word w;
        w              = rand_word();
        w.slot         = SLOT_FIELD_W'(s);
        w.sample_index = INDEX_FIELD_W'(idx);
        w.sample_value = SAMPLE_W'(val);
        push_cmd(OP_WRITE, w);
        sample_known[s][idx] = 1'b1;
        while (known_run[s] < SLOT_SAMPLES && sample_known[s][known_run[s]]) begin
            known_run[s]++;
        end
    endtask

    task automatic gen_length(int s, int len);
        t_in_word w;
        w            = rand_word();
        w.slot       = SLOT_FIELD_W'(s);
        w.new_length = NLEN_W'(len);
        push_cmd(OP_LENGTH, w);
        if (len <= SLOT_SAMPLES) begin
            gen_len[s] = len;
        end
    endtask

    task automatic gen_trigger(int s, logic [63:0] stp);
        t_in_word w;
        w      = rand_word();
        w.slot = SLOT_FIELD_W'(s);
        w.step = STEP_FIELD_W'(stp);
        push_cmd(OP_TRIGGER, w);
    endtask

    function automatic logic [63:0] pick_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) return 64'd0;
        if (r < 15) return 64'($urandom_range(1, 1000));
        if (r < 55) return {32'd0, $urandom};
        if (r < 62) return {30'd0, 2'($urandom_range(1, 3)), 32'd0};
        if (r < 85) return {30'd0, 2'($urandom_range(1, 2)), $urandom};
        if (r < 92) return STEP_KEEP;
        return 64'({$urandom, $urandom}) & STEP_KEEP;
    endfunction

    function automatic int pick_play_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(2, 16);
        if (r < 85) return $urandom_range(17, 64);
        if (r < 92) return $urandom_range(0, 1);
        return $urandom_range(65, 300);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                due_outputs.push_back(bank_apply(cur_cmd.op, cur_cmd.word));
            end
            if (s_axis_tvalid && !s_axis_tready) begin
                // The word stays on the bus until it is taken.
            end else if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (cmd_queue.size() > 0
                         && !(cmd_queue[0].drain && due_outputs.size() > 0)) begin
                cur_cmd = cmd_queue.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= cur_cmd.word;
                s_axis_tuser  <= cur_cmd.op;
                tx_gap = idle_len(tx_calm);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                check_output(t_out_word'(m_axis_tdata));
                results_seen++;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (results_seen >= next_long_hold) begin
                // A long hold-off lets the output buffer fill and back-pressure the input.
                hold_left = LONG_HOLD;
                next_long_hold += 500;
                m_axis_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                rx_gap = idle_len(rx_calm);
            end
        end
    end

    initial begin
        int r;
        int s;
        int hot;
        int len;
        int base;
        int total_items;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            pb_len[i]    = '0;
            pb_whole[i]  = '0;
            pb_frac[i]   = '0;
            pb_step[i]   = '0;
            known_run[i] = 0;
            gen_len[i]   = 0;
        end

        gen_simple(OP_NEXT, 0);
        gen_trigger(1, pick_step());
        gen_length(2, 65535);
        gen_length(2, SLOT_SAMPLES);
        gen_length(3, 1);
        gen_trigger(3, 64'd5);
        gen_write(0, 0, -32768);
        gen_write(0, 1, 32767);
        gen_write(0, 2, 0);
        gen_write(SLOT_COUNT - 1, SLOT_SAMPLES - 1, -1);
        gen_length(0, 3);
        gen_trigger(0, 64'd0);
        gen_simple(OP_NEXT, 0);
        gen_trigger(0, STEP_KEEP);
        gen_simple(OP_NEXT, 0);
        gen_simple(OP_NEXT, 0);
        gen_trigger(0, 64'h8000_0000);
        for (int i = 0; i < 5; i++) begin
            gen_simple(OP_NEXT, 0);
        end
        gen_simple(OP_W'(OP_NEXT + 1), 0);
        gen_simple({OP_W{1'b1}}, 1);
        gen_simple(OP_STOP, 2);

        drain_next = 1'b1;
        base = cmd_queue.size();
        hot  = 0;
        while (cmd_queue.size() < base + RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                s   = $urandom_range(0, SLOT_COUNT - 1);
                len = pick_play_len();
                for (int i = known_run[s]; i < len; i++) begin
                    gen_write(s, i, $urandom_range(0, 65535));
                end
                if (len > 0 && $urandom_range(0, 1)) begin
                    gen_write(s, $urandom_range(0, len - 1), $urandom_range(0, 65535));
                end
                gen_length(s, len);
                if ($urandom_range(0, 99) < 80) begin
                    gen_trigger(s, pick_step());
                end
                hot = s;
            end else if (r < 22) begin
                s = ($urandom_range(0, 1)) ? hot : $urandom_range(0, SLOT_COUNT - 1);
                if (gen_len[s] < MIN_PLAY_LEN || gen_len[s] <= known_run[s]) begin
                    gen_trigger(s, pick_step());
                    hot = s;
                end else begin
                    gen_simple(OP_NEXT, s);
                end
            end else if (r < 70) begin
                s = ($urandom_range(0, 9) < 7) ? hot : $urandom_range(0, SLOT_COUNT - 1);
                gen_simple(OP_NEXT, s);
            end else if (r < 75) begin
                gen_simple(OP_STOP, $urandom_range(0, SLOT_COUNT - 1));
            end else if (r < 80) begin
                s = $urandom_range(0, SLOT_COUNT - 1);
                r = $urandom_range(0, 9);
                if (r < 3) begin
                    gen_length(s, $urandom_range(SLOT_SAMPLES + 1, 65535));
                end else if (r < 5) begin
                    gen_length(s, SLOT_SAMPLES);
                end else begin
                    gen_length(s, $urandom_range(0, SLOT_SAMPLES));
                end
            end else if (r < 86) begin
                gen_write($urandom_range(0, SLOT_COUNT - 1), $urandom_range(0, SLOT_SAMPLES - 1),
                          $urandom_range(0, 65535));
            end else if (r < 89) begin
                gen_simple(OP_W'($urandom_range(OP_NEXT + 1, (1 << OP_W) - 1)),
                           $urandom_range(0, SLOT_COUNT - 1));
            end else if (r < 91) begin
                drain_next = 1'b1;
            end else begin
                gen_simple(OP_NEXT, $urandom_range(0, SLOT_COUNT - 1));
            end
        end
        total_items = cmd_queue.size();

        @(posedge i_clk);
        while (results_seen < total_items) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("oneshot_sample_bank_player_core: match");
        end else begin
            $display("oneshot_sample_bank_player_core: mismatch");
        end
        $finish;
    end

endmodule
